### hdl/dvrt_pkg.sv
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;

  localparam int unsigned AddrW = 32;

  typedef enum logic [1:0] {
    CMD_ADVERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_NOCHANGE  = 4'd0,
    ST_CHANGED   = 4'd1,
    ST_BADMETRIC = 4'd2,
    ST_ZEROADDR  = 4'd3,
    ST_IFACEDOWN = 4'd4,
    ST_FULL      = 4'd5,
    ST_HIT       = 4'd6,
    ST_MISS      = 4'd7,
    ST_TICKDONE  = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    REG_TIMEOUT = 3'd0,
    REG_LINKUP  = 3'd1,
    REG_NET0    = 3'd2,
    REG_MASK0   = 3'd3,
    REG_NET1    = 3'd4,
    REG_MASK1   = 3'd5,
    REG_NET2    = 3'd6,
    REG_MASK2   = 3'd7
  } reg_e;

  typedef enum logic [5:0] {
    OP_IDLE   = 6'b000001,
    OP_SCAN   = 6'b000010,
    OP_CONN   = 6'b000100,
    OP_INSERT = 6'b001000,
    OP_RESULT = 6'b010000,
    OP_UNUSED = 6'b100000
  } phase_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // latch the beat and clear scan state
    logic scan;      // visit one slot (main pass)
    logic conn;      // visit one slot (connected-route pass)
    logic conn_next; // finish current interface of connected pass
    logic finish;    // commit and load result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_slot;
    logic last_iface;
    logic early_done;
  } dp_sts_t;

endpackage

### hdl/distance_vector_route_table_unit.sv
// Top level of the distance-vector route table.
//
//  group    direction  payload
//  s_axis   in         tdata: address, netmask, adv_metric, source_router; tuser: cmd, iface
//  m_axis   out        tdata: gateway, out_iface, metric, removed, update; tuser: status
//  cfg      in         index 3 bits, data 32 bits
//
// Each command is carried out by the one-slot-per-cycle table scan; an advert or an
// empty command may end the scan early, and a tick adds one connected-route pass per
// interface. Reset clears all valid bits at once, with no clearing pass.
// One beat is in work at a time; the result register frees the next beat
// as soon as the result is loaded, and a held result stalls only the finish.
module distance_vector_route_table_unit import dvrt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH     = 32,
  parameter int unsigned NUM_IFACES      = 3,
  parameter int unsigned METRIC_INFINITY = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address[31:0], netmask[63:32], adv_metric[95:64], source_router[127:96]
  input  logic [127:0] s_axis_tdata,
  // cmd[1:0], arrival_iface[3:2]
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // gateway[31:0], out_iface[33:32], route_metric[38:34], removed_count[44:39],
  // update_needed[45], zero fill above
  output logic [47:0]  m_axis_tdata,
  // status[3:0]
  output logic [3:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic busy, in_fire, out_take;
  logic [3:0] st;
  logic upd;
  logic [31:0] nh;
  logic [1:0] oif;
  logic [4:0] met;
  logic [5:0] rem;
  logic is_tick_q;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_tick_q <= 1'b0;
    end else if (in_fire) begin
      is_tick_q <= (s_axis_tuser[1:0] == CMD_TICK);
    end
  end

  dvrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire),
    .is_tick_i(is_tick_q),
    .out_free_i(!m_axis_tvalid || m_axis_tready),
    .sts_i(sts),
    .cmd_o(cmd),
    .busy_o(busy)
  );

  dvrt_datapath #(
    .TableDepth(TABLE_DEPTH), .NumIfaces(NUM_IFACES), .MetricInfinity(METRIC_INFINITY)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .in_cmd_i(s_axis_tuser[1:0]),
    .in_address_i(s_axis_tdata[31:0]),
    .in_netmask_i(s_axis_tdata[63:32]),
    .in_metric_i(s_axis_tdata[95:64]),
    .in_source_i(s_axis_tdata[127:96]),
    .in_iface_i(s_axis_tuser[3:2]),
    .in_last_i(s_axis_tlast),
    .cfg_we_i(cfg_valid_i),
    .cfg_idx_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .out_take_i(out_take),
    .out_valid_o(m_axis_tvalid),
    .out_status_o(st),
    .out_update_o(upd),
    .out_gateway_o(nh),
    .out_iface_o(oif),
    .out_metric_o(met),
    .out_removed_o(rem)
  );

  assign m_axis_tuser = st;
  assign m_axis_tdata = {2'b00, upd, rem, met, oif, nh};

endmodule

### hdl/dvrt_ctrl.sv
// Sequencing controller of the route table.
module dvrt_ctrl import dvrt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    is_tick_i,
  input  logic    out_free_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  phase_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      OP_IDLE: begin
        if (in_fire_i) begin
          cmd_o.start = 1'b1;
          state_d = OP_SCAN;
        end
      end
      OP_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.early_done) begin
          state_d = OP_RESULT;
        end else if (sts_i.last_slot) begin
          state_d = is_tick_i ? OP_CONN : OP_RESULT;
        end
      end
      OP_CONN: begin
        cmd_o.conn = 1'b1;
        if (sts_i.last_slot) begin
          state_d = OP_INSERT;
        end
      end
      OP_INSERT: begin
        cmd_o.conn_next = 1'b1;
        state_d = sts_i.last_iface ? OP_RESULT : OP_CONN;
      end
      OP_RESULT: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d = OP_IDLE;
        end
      end
      default: state_d = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= OP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != OP_IDLE);

endmodule

### hdl/dvrt_datapath.sv
// Route table storage, slot scan logic and result register.
module dvrt_datapath import dvrt_pkg::*; #(
  parameter int unsigned TableDepth     = 32,
  parameter int unsigned NumIfaces      = 3,
  parameter int unsigned MetricInfinity = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [AddrW-1:0]    in_address_i,
  input  logic [AddrW-1:0]    in_netmask_i,
  input  logic [AddrW-1:0]    in_metric_i,
  input  logic [AddrW-1:0]    in_source_i,
  input  logic [1:0]          in_iface_i,
  input  logic                in_last_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [AddrW-1:0]    cfg_data_i,
  input  logic                out_take_i,
  output logic                out_valid_o,
  output logic [3:0]          out_status_o,
  output logic                out_update_o,
  output logic [AddrW-1:0]    out_gateway_o,
  output logic [1:0]          out_iface_o,
  output logic [4:0]          out_metric_o,
  output logic [5:0]          out_removed_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);
  localparam logic [4:0] Inf = 5'(MetricInfinity);

  // Configuration.
  logic [7:0]       timeout_q;
  logic [2:0]       linkup_q;
  logic [AddrW-1:0] net_q [3];
  logic [AddrW-1:0] nmask_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 8'd20;
      linkup_q  <= 3'b111;
      for (int i = 0; i < 3; i++) begin
        net_q[i]   <= '0;
        nmask_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIMEOUT: timeout_q <= cfg_data_i[7:0];
        REG_LINKUP:  linkup_q  <= cfg_data_i[2:0];
        REG_NET0:    net_q[0]  <= cfg_data_i;
        REG_MASK0:   nmask_q[0] <= cfg_data_i;
        REG_NET1:    net_q[1]  <= cfg_data_i;
        REG_MASK1:   nmask_q[1] <= cfg_data_i;
        REG_NET2:    net_q[2]  <= cfg_data_i;
        REG_MASK2:   nmask_q[2] <= cfg_data_i;
        default:     timeout_q <= timeout_q;
      endcase
    end
  end

  function automatic logic link_up(logic [2:0] up, logic [1:0] i);
    link_up = (32'(i) < NumIfaces) && (i != 2'd3) && up[i];
  endfunction

  // Table.
  logic [TableDepth-1:0] valid_q;
  logic [AddrW-1:0] dest_q [TableDepth];
  logic [AddrW-1:0] emask_q [TableDepth];
  logic [AddrW-1:0] gw_q [TableDepth];
  logic [1:0]       eif_q [TableDepth];
  logic [4:0]       emet_q [TableDepth];
  logic [7:0]       age_q [TableDepth];

  // Latched beat.
  logic [1:0]       cmd_q;
  logic [AddrW-1:0] addr_q, nmsk_q, met_q, src_q;
  logic [1:0]       arr_q;
  logic             last_q, pkt_changed_q;

  // Scan state.
  logic [IdxW-1:0] idx_q;
  logic [1:0]      cif_q;
  logic            hit_q, free_q, found_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic [5:0]      best_len_q;
  logic [5:0]      removed_q;
  logic [3:0]      pre_st_q;

  // Output register.
  logic             ov_q;
  logic [3:0]       ost_q;
  logic             oupd_q;
  logic [AddrW-1:0] ogw_q;
  logic [1:0]       oif_q;
  logic [4:0]       omet_q;
  logic [5:0]       orem_q;

  // Advert pre-checks, evaluated on the incoming beat.
  logic [3:0] pre_st_d;
  always_comb begin
    pre_st_d = ST_NOCHANGE;
    for (int i = 0; i < 3; i++) begin
      if (i < NumIfaces && ((net_q[i] & nmask_q[i]) == (in_address_i & in_netmask_i)) &&
          !linkup_q[i]) begin
        pre_st_d = ST_IFACEDOWN;
      end
    end
    if (pre_st_d == ST_NOCHANGE) begin
      if (32'(in_iface_i) >= NumIfaces) begin
        pre_st_d = ST_IFACEDOWN;
      end else if (in_metric_i > AddrW'(MetricInfinity)) begin
        pre_st_d = ST_BADMETRIC;
      end else if (in_address_i == '0 || in_netmask_i == '0) begin
        pre_st_d = ST_ZEROADDR;
      end
    end
  end

  logic        cur_v;
  logic [AddrW-1:0] cur_dest, cur_mask, cur_gw;
  logic [1:0]  cur_if;
  logic [4:0]  cur_met;
  logic [7:0]  cur_age, aged;
  logic [5:0]  cur_len;
  logic        lk_match, tick_rm, conn_match;
  logic [AddrW:0] met_p1;

  always_comb begin
    cur_v    = valid_q[idx_q];
    cur_dest = dest_q[idx_q];
    cur_mask = emask_q[idx_q];
    cur_gw   = gw_q[idx_q];
    cur_if   = eif_q[idx_q];
    cur_met  = emet_q[idx_q];
    cur_age  = age_q[idx_q];
    cur_len  = 6'($countones(cur_mask));
    aged     = (cur_age == 8'hFF) ? cur_age : cur_age + 8'd1;
    tick_rm  = (aged > timeout_q) || !link_up(linkup_q, cur_if);
    lk_match = cur_v && (cur_met < Inf) &&
               (cur_dest == addr_q || cur_dest == (addr_q & cur_mask));
    conn_match = cur_v && (cur_if == cif_q) && (cur_gw == '0);
    met_p1   = {1'b0, met_q} + 1'b1;
  end

  assign sts_o.last_slot  = (idx_q == LastIdx);
  assign sts_o.last_iface = (32'(cif_q) + 1 >= NumIfaces);
  assign sts_o.early_done = (cmd_q == CMD_ADVERT && (pre_st_q != ST_NOCHANGE ||
                             (cur_v && cur_dest == addr_q))) || cmd_q == CMD_NONE;

  logic [3:0] fin_st;
  logic       fin_chg;
  always_comb begin
    fin_st  = ST_NOCHANGE;
    fin_chg = 1'b0;
    case (cmd_q)
      CMD_ADVERT: begin
        if (pre_st_q != ST_NOCHANGE) begin
          fin_st = pre_st_q;
        end else if (hit_q) begin
          if ({28'd0, emet_q[hit_idx_q]} > met_p1) begin
            fin_st = ST_CHANGED;
          end
        end else if (met_q < AddrW'(MetricInfinity)) begin
          fin_st = free_q ? ST_CHANGED : ST_FULL;
        end
        fin_chg = (fin_st == ST_CHANGED);
      end
      CMD_TICK:   fin_st = ST_TICKDONE;
      CMD_LOOKUP: fin_st = found_q ? ST_HIT : ST_MISS;
      default:    fin_st = ST_NOCHANGE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pkt_changed_q <= 1'b0;
      ov_q <= 1'b0;
      idx_q <= '0;
      cif_q <= '0;
    end else begin
      if (out_take_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.start) begin
        cmd_q <= in_cmd_i; addr_q <= in_address_i; nmsk_q <= in_netmask_i;
        met_q <= in_metric_i; src_q <= in_source_i; arr_q <= in_iface_i;
        last_q <= in_last_i; pre_st_q <= pre_st_d;
        idx_q <= '0; cif_q <= '0;
        hit_q <= 1'b0; free_q <= 1'b0; found_q <= 1'b0;
        best_len_q <= '0; removed_q <= '0;
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + 1'b1;
        // A slot that the tick removes counts as free for the connected-route pass.
        if ((!cur_v || (cmd_q == CMD_TICK && tick_rm)) && !free_q) begin
          free_q <= 1'b1; free_idx_q <= idx_q;
        end
        case (cmd_q)
          CMD_ADVERT: begin
            if (cur_v && cur_dest == addr_q) begin
              hit_q <= 1'b1; hit_idx_q <= idx_q;
            end
          end
          CMD_TICK: begin
            if (cur_v) begin
              age_q[idx_q] <= aged;
              if (tick_rm) begin
                valid_q[idx_q] <= 1'b0;
                removed_q <= removed_q + 1'b1;
              end
            end
          end
          CMD_LOOKUP: begin
            if (lk_match && (!found_q || cur_len > best_len_q)) begin
              found_q <= 1'b1; best_idx_q <= idx_q; best_len_q <= cur_len;
            end
          end
          default: idx_q <= idx_q + 1'b1;
        endcase
        if (sts_o.last_slot || sts_o.early_done) begin
          idx_q <= '0;
        end
      end
      if (cmd_i.conn) begin
        idx_q <= sts_o.last_slot ? '0 : idx_q + 1'b1;
        if (link_up(linkup_q, cif_q)) begin
          if (conn_match && !found_q) begin
            found_q <= 1'b1;
            emet_q[idx_q] <= '0;
            age_q[idx_q] <= '0;
          end
          if (!cur_v && !free_q) begin
            free_q <= 1'b1; free_idx_q <= idx_q;
          end
        end
      end
      if (cmd_i.conn_next) begin
        if (link_up(linkup_q, cif_q) && !found_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
          dest_q[free_idx_q]  <= net_q[cif_q] & nmask_q[cif_q];
          emask_q[free_idx_q] <= nmask_q[cif_q];
          gw_q[free_idx_q]    <= '0;
          eif_q[free_idx_q]   <= cif_q;
          emet_q[free_idx_q]  <= '0;
          age_q[free_idx_q]   <= '0;
        end
        cif_q <= cif_q + 1'b1;
        found_q <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        ov_q  <= 1'b1;
        ost_q <= fin_st;
        oupd_q <= 1'b0; ogw_q <= '0; oif_q <= '0; omet_q <= '0; orem_q <= '0;
        if (cmd_q == CMD_ADVERT) begin
          if (pre_st_q == ST_NOCHANGE) begin
            if (hit_q) begin
              if (met_q < AddrW'(MetricInfinity)) begin
                age_q[hit_idx_q] <= '0;
              end
              if (fin_chg) begin
                emet_q[hit_idx_q] <= met_p1[4:0];
                gw_q[hit_idx_q]   <= src_q;
                eif_q[hit_idx_q]  <= arr_q;
              end
            end else if (fin_chg) begin
              valid_q[free_idx_q] <= 1'b1;
              dest_q[free_idx_q]  <= addr_q;
              emask_q[free_idx_q] <= nmsk_q;
              gw_q[free_idx_q]    <= src_q;
              eif_q[free_idx_q]   <= arr_q;
              emet_q[free_idx_q]  <= met_p1[4:0];
              age_q[free_idx_q]   <= '0;
            end
          end
          if (last_q) begin
            oupd_q <= pkt_changed_q | fin_chg;
            pkt_changed_q <= 1'b0;
          end else if (fin_chg) begin
            pkt_changed_q <= 1'b1;
          end
        end else if (cmd_q == CMD_TICK) begin
          orem_q <= removed_q;
        end else if (cmd_q == CMD_LOOKUP && found_q) begin
          ogw_q  <= gw_q[best_idx_q];
          oif_q  <= eif_q[best_idx_q];
          omet_q <= emet_q[best_idx_q];
        end
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign out_status_o   = ost_q;
  assign out_update_o   = oupd_q;
  assign out_gateway_o  = ogw_q;
  assign out_iface_o    = oif_q;
  assign out_metric_o   = omet_q;
  assign out_removed_o  = orem_q;

endmodule

### tb/distance_vector_route_table_unit_tb.sv
// Self-checking testbench for the distance-vector route table unit.
module distance_vector_route_table_unit_tb;
  import dvrt_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] metric;
    logic [31:0] source;
    logic [1:0]  iface;
    logic        last;
  } route_item_t;

  typedef struct packed {
    status_e     status;
    logic        update;
    logic [31:0] gateway;
    logic [1:0]  out_iface;
    logic [4:0]  metric;
    logic [5:0]  removed;
  } route_answer_t;

  localparam int Depth = 32;
  localparam int Ifaces = 3;
  localparam int Infinity = 16;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  distance_vector_route_table_unit dut (.*);

  // Shadow copy of the table and its configuration.
  logic [7:0]  timeout_q;
  logic [2:0]  link_q;
  logic [31:0] net_q [Ifaces];
  logic [31:0] netmask_q [Ifaces];
  logic        rt_valid [Depth];
  logic [31:0] rt_dest [Depth];
  logic [31:0] rt_mask [Depth];
  logic [31:0] rt_gw [Depth];
  logic [1:0]  rt_iface [Depth];
  logic [4:0]  rt_metric [Depth];
  logic [7:0]  rt_age [Depth];
  logic        pkt_changed;

  route_item_t   pending_items [$];
  route_answer_t expected_answers [$];
  route_item_t   cur_item;
  int            gap_cnt;
  int            stall_cnt;
  int            errors;
  logic [31:0]   subnet_pool [48];

  function automatic bit link_is_up(logic [1:0] i);
    return (i < Ifaces) && link_q[i];
  endfunction

  function automatic int lowest_free();
    for (int k = 0; k < Depth; k++) if (!rt_valid[k]) return k;
    return -1;
  endfunction

  function automatic void add_route(int k, logic [31:0] d, logic [31:0] m, logic [31:0] g,
                                    logic [1:0] ifc, logic [4:0] met);
    rt_valid[k] = 1'b1;
    rt_dest[k] = d;
    rt_mask[k] = m;
    rt_gw[k] = g;
    rt_iface[k] = ifc;
    rt_metric[k] = met;
    rt_age[k] = 8'd0;
  endfunction

  function automatic status_e apply_advert(route_item_t it);
    int hit;
    int k;
    hit = -1;
    for (int i = 0; i < Ifaces; i++)
      if ((net_q[i] & netmask_q[i]) == (it.addr & it.mask) && !link_is_up(i[1:0]))
        return ST_IFACEDOWN;
    if (it.iface >= Ifaces) return ST_IFACEDOWN;
    if (it.metric > Infinity) return ST_BADMETRIC;
    if (it.addr == 0 || it.mask == 0) return ST_ZEROADDR;
    for (k = 0; k < Depth; k++)
      if (rt_valid[k] && rt_dest[k] == it.addr) begin
        hit = k;
        break;
      end
    if (hit >= 0) begin
      if (it.metric < Infinity) rt_age[hit] = 8'd0;
      if (rt_metric[hit] > it.metric + 1) begin
        rt_metric[hit] = 5'(it.metric + 1);
        rt_gw[hit] = it.source;
        rt_iface[hit] = it.iface;
        return ST_CHANGED;
      end
      return ST_NOCHANGE;
    end
    if (it.metric < Infinity) begin
      k = lowest_free();
      if (k < 0) return ST_FULL;
      add_route(k, it.addr, it.mask, it.source, it.iface, 5'(it.metric + 1));
      return ST_CHANGED;
    end
    return ST_NOCHANGE;
  endfunction

  function automatic logic [5:0] apply_tick();
    int removed;
    int k;
    bit found;
    removed = 0;
    for (k = 0; k < Depth; k++) begin
      if (rt_valid[k]) begin
        if (rt_age[k] != 8'hFF) rt_age[k]++;
        if (rt_age[k] > timeout_q || !link_is_up(rt_iface[k])) begin
          rt_valid[k] = 1'b0;
          removed++;
        end
      end
    end
    for (int i = 0; i < Ifaces; i++) begin
      found = 0;
      if (link_is_up(i[1:0])) begin
        for (k = 0; k < Depth; k++)
          if (rt_valid[k] && rt_iface[k] == i && rt_gw[k] == 0) begin
            rt_metric[k] = 5'd0;
            rt_age[k] = 8'd0;
            found = 1;
            break;
          end
        if (!found) begin
          k = lowest_free();
          if (k >= 0) add_route(k, net_q[i] & netmask_q[i], netmask_q[i], 32'd0, i[1:0], 5'd0);
        end
      end
    end
    return 6'(removed);
  endfunction

  function automatic route_answer_t predict_route(route_item_t it);
    route_answer_t a;
    int best;
    int best_len;
    a = '{ST_NOCHANGE, 1'b0, 32'd0, 2'd0, 5'd0, 6'd0};
    best = -1;
    best_len = 0;
    case (it.cmd)
      CMD_ADVERT: begin
        a.status = apply_advert(it);
        if (a.status == ST_CHANGED) pkt_changed = 1'b1;
        if (it.last) begin
          a.update = pkt_changed;
          pkt_changed = 1'b0;
        end
      end
      CMD_TICK: begin
        a.status = ST_TICKDONE;
        a.removed = apply_tick();
      end
      CMD_LOOKUP: begin
        for (int k = 0; k < Depth; k++) begin
          if (rt_valid[k] && rt_metric[k] < Infinity &&
              (rt_dest[k] == it.addr || rt_dest[k] == (it.addr & rt_mask[k])) &&
              (best < 0 || $countones(rt_mask[k]) > best_len)) begin
            best = k;
            best_len = $countones(rt_mask[k]);
          end
        end
        if (best >= 0) begin
          a.status = ST_HIT;
          a.gateway = rt_gw[best];
          a.out_iface = rt_iface[best];
          a.metric = rt_metric[best];
        end else begin
          a.status = ST_MISS;
        end
      end
      default: a.status = ST_NOCHANGE;
    endcase
    return a;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("distance_vector_route_table_unit_tb: FAIL");
    $finish;
  end

  // Driver of the input stream.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_answers.push_back(predict_route(cur_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_axis_tdata <= {cur_item.source, cur_item.metric, cur_item.mask, cur_item.addr};
          s_axis_tuser <= {cur_item.iface, cur_item.cmd};
          s_axis_tlast <= cur_item.last;
          s_axis_tvalid <= 1'b1;
          gap_cnt = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor of the result stream.
  always @(posedge clk_i) begin
    route_answer_t e;
    route_answer_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{status_e'(m_axis_tuser), m_axis_tdata[45], m_axis_tdata[31:0],
                m_axis_tdata[33:32], m_axis_tdata[38:34], m_axis_tdata[44:39]};
        if (expected_answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: status %0d", got.status);
        end else begin
          e = expected_answers.pop_front();
          if (got != e) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected st=%0d upd=%0b gw=%h if=%0d met=%0d rem=%0d, ",
                       e.status, e.update, e.gateway, e.out_iface, e.metric, e.removed,
                       "got st=%0d upd=%0b gw=%h if=%0d met=%0d rem=%0d",
                       got.status, got.update, got.gateway, got.out_iface, got.metric,
                       got.removed);
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
      end else begin
        m_axis_tready <= !m_axis_tready;
        stall_cnt = m_axis_tready ? $urandom_range(0, 30) : pick_gap();
      end
    end
  end

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_TIMEOUT: timeout_q = data[7:0];
      REG_LINKUP: link_q = data[2:0];
      default: begin
        if (idx[0]) netmask_q[(idx - 2) >> 1] = data;
        else net_q[(idx - 2) >> 1] = data;
      end
    endcase
  endtask

  // Checked at the falling edge, after every driver update of the rising edge has settled.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() > 0 || s_axis_tvalid || expected_answers.size() > 0);
  endtask

  task automatic push(cmd_e c, logic [31:0] a, logic [31:0] m, logic [31:0] met,
                      logic [31:0] src, logic [1:0] ifc, logic last);
    pending_items.push_back('{c, a, m, met, src, ifc, last});
  endtask

  task automatic push_random();
    int r;
    int k;
    logic [31:0] m;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 47);
    case ($urandom_range(0, 3))
      0: m = 32'hFF00_0000;
      1: m = 32'hFFFF_0000;
      2: m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    if (r < 55)
      push(CMD_ADVERT, subnet_pool[k], m,
           ($urandom_range(0, 9) == 0) ? 32'd16 : $urandom_range(0, 15),
           ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom, $urandom_range(0, 2),
           $urandom_range(0, 3) == 0);
    else if (r < 70)
      push(CMD_LOOKUP, subnet_pool[k] | $urandom_range(0, 255), $urandom, $urandom, $urandom,
           $urandom_range(0, 3), $urandom_range(0, 1));
    else if (r < 82)
      push(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3),
           $urandom_range(0, 1));
    else
      push(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
           $urandom_range(0, 3), $urandom_range(0, 1));
  endtask

  initial begin
    logic [7:0]  timeouts [6];
    logic [2:0]  links [6];
    timeouts = '{8'd20, 8'd1, 8'd255, 8'd5, 8'd40, 8'd3};
    links = '{3'd7, 3'd5, 3'd0, 3'd7, 3'd3, 3'd6};
    errors = 0;
    stall_cnt = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_TIMEOUT;
    cfg_data_i = '0;
    timeout_q = 8'd20;
    link_q = 3'd7;
    pkt_changed = 1'b0;
    for (int i = 0; i < Ifaces; i++) begin
      net_q[i] = '0;
      netmask_q[i] = '0;
    end
    for (int k = 0; k < Depth; k++) rt_valid[k] = 1'b0;
    for (int k = 0; k < 48; k++) subnet_pool[k] = 32'h0A00_0000 | (k << 12) | (k << 8);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_NET0, 32'h0A00_0001);
    write_reg(REG_MASK0, 32'hFFFF_FF00);
    write_reg(REG_NET1, 32'hC0A8_0100);
    write_reg(REG_MASK1, 32'hFFFF_FF00);
    write_reg(REG_NET2, 32'hAC10_0000);
    write_reg(REG_MASK2, 32'hFFFF_0000);
    write_reg(REG_TIMEOUT, 8'd20);
    write_reg(REG_LINKUP, 3'd7);

    // Directed part: connected routes, metric limits, zero fields, bad iface, lookups.
    push(CMD_LOOKUP, 32'h0A00_0005, 0, 0, 0, 0, 0);
    push(CMD_TICK, 0, 0, 0, 0, 0, 0);
    push(CMD_ADVERT, 32'h0B00_0000, 32'hFF00_0000, 32'd0, 32'h0A00_0002, 2'd0, 1'b0);
    push(CMD_ADVERT, 32'h0C00_0000, 32'hFF00_0000, 32'd15, 32'hC0A8_0102, 2'd1, 1'b0);
    push(CMD_ADVERT, 32'h0D00_0000, 32'hFF00_0000, 32'd16, 32'hC0A8_0102, 2'd1, 1'b1);
    push(CMD_ADVERT, 32'h0E00_0000, 32'hFF00_0000, 32'd17, 32'hFFFF_FFFF, 2'd2, 1'b1);
    push(CMD_ADVERT, 32'h0E00_0000, 32'hFF00_0000, 32'hFFFF_FFFF, 32'd1, 2'd2, 1'b0);
    push(CMD_ADVERT, 32'h0000_0000, 32'hFF00_0000, 32'd1, 32'd1, 2'd0, 1'b0);
    push(CMD_ADVERT, 32'h0F00_0000, 32'h0000_0000, 32'd1, 32'd1, 2'd0, 1'b0);
    push(CMD_ADVERT, 32'h0F00_0000, 32'hFF00_0000, 32'd1, 32'd1, 2'd3, 1'b1);
    push(CMD_ADVERT, 32'h0C00_0000, 32'hFF00_0000, 32'd3, 32'hAC10_0009, 2'd2, 1'b0);
    push(CMD_ADVERT, 32'h0C00_0000, 32'hFF00_0000, 32'd9, 32'hAC10_0009, 2'd2, 1'b1);
    push(CMD_ADVERT, 32'h0C0C_0000, 32'hFFFF_0000, 32'd2, 32'h0A00_0003, 2'd0, 1'b1);
    push(CMD_LOOKUP, 32'h0C0C_0C0C, 0, 0, 0, 0, 0);
    push(CMD_LOOKUP, 32'h0C01_0101, 0, 0, 0, 0, 0);
    push(CMD_LOOKUP, 32'h0A00_00FF, 0, 0, 0, 0, 0);
    push(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    push(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1);
    push(CMD_TICK, 0, 0, 0, 0, 0, 0);
    drain();
    write_reg(REG_LINKUP, 3'd5);
    push(CMD_ADVERT, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd1, 32'd9, 2'd0, 1'b1);
    push(CMD_TICK, 0, 0, 0, 0, 0, 0);
    push(CMD_LOOKUP, 32'h0C00_0001, 0, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_TIMEOUT, timeouts[p]);
      write_reg(REG_LINKUP, links[p]);
      if (p == 3) begin
        write_reg(REG_NET1, 32'h0000_0000);
        write_reg(REG_MASK1, 32'h0000_0000);
        write_reg(REG_NET2, 32'hFFFF_FFFF);
        write_reg(REG_MASK2, 32'hFFFF_FFFF);
      end
      if (p == 4) begin
        write_reg(REG_NET0, 32'h0A00_3000);
        write_reg(REG_MASK0, 32'hFFFF_F000);
      end
      for (int n = 0; n < 115; n++) push_random();
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("distance_vector_route_table_unit_tb: PASS");
    end else begin
      $display("distance_vector_route_table_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/dvrt_pkg.sv
hdl/dvrt_ctrl.sv
hdl/dvrt_datapath.sv
hdl/distance_vector_route_table_unit.sv
tb/distance_vector_route_table_unit_tb.sv
